// ----- hdl/acmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// acmpc_pkg
// Types and codes shared by the multi-pattern match counter.
// ----------------------------------------------------------------------------
package acmpc_pkg;

    localparam logic [2:0] OP_BEGIN_PAT  = 3'd0;
    localparam logic [2:0] OP_PAT_LETTER = 3'd1;
    localparam logic [2:0] OP_END_PAT    = 3'd2;
    localparam logic [2:0] OP_BUILD      = 3'd3;
    localparam logic [2:0] OP_BEGIN_TEXT = 3'd4;
    localparam logic [2:0] OP_TEXT_LETTER = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_LINKS = 2'd2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [4:0] symbol;
    } item_t;

    typedef struct packed {
        logic [31:0] match_total;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PL_RD,
        S_PE_RD,
        S_B_ROOT,
        S_B_ROOTW,
        S_B_R0,
        S_B_R0W,
        S_B_R0A,
        S_B_POP,
        S_B_POPW,
        S_B_NF,
        S_B_CH,
        S_B_CHW,
        S_G_TW,
        S_G_FW,
        S_B_TACC,
        S_B_WR,
        S_T_AW,
        S_PUSH
    } state_t;

endpackage

// ----- hdl/acmpc_ram.sv -----
// ----------------------------------------------------------------------------
// acmpc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module acmpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/aho_corasick_multi_pattern_counter.sv -----
// ----------------------------------------------------------------------------
// aho_corasick_multi_pattern_counter
// Trie loader, breadth-first link builder and text matcher over node RAMs.
// ----------------------------------------------------------------------------
// Usage: requests arrive on item (opcode, symbol) with item_valid/item_ready;
// every request yields exactly one result (match_total, status) on
// result_valid/result_ready, in request order.
// One request is in flight at a time. A text letter may follow failure links;
// each step is one read of the transition RAM and one of the node RAM, both
// registered reads.
// The build request walks every node and each letter of each node, and
// follows failure links for each transition that exists.
// After reset the block sweeps the transition RAM and clears the node RAM;
// item_ready stays low meanwhile.
// The result register holds a finished result while the receiver stalls;
// the next request may be taken meanwhile, and its result waits until the
// register frees.
// ----------------------------------------------------------------------------
module aho_corasick_multi_pattern_counter
    import acmpc_pkg::*;
#(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(ALPHABET_SIZE + 1);
    localparam int TD  = MAX_NODES * ALPHABET_SIZE;
    localparam int TAW = $clog2(TD);
    localparam int NDW = NW + 16;

    function automatic logic [TAW-1:0] tt_addr(input logic [NW-1:0] n,
                                               input logic [CW-1:0] c);
        tt_addr = TAW'(32'(n) * ALPHABET_SIZE + 32'(c));
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat16 = s[16] ? 16'hFFFF : s[15:0];
    endfunction

    state_t          state_reg, state_next;
    logic [CW-1:0]   sym_reg, sym_next;
    logic [NW-1:0]   cursor_reg, cursor_next;
    logic [NW:0]     nodes_used_reg, nodes_used_next;
    logic [31:0]     total_reg, total_next;
    logic            built_reg, built_next;
    logic            ovf_reg, ovf_next;
    logic [NW:0]     head_reg, head_next;
    logic [NW:0]     tail_reg, tail_next;
    logic [CW-1:0]   cidx_reg, cidx_next;
    logic [NW-1:0]   now_reg, now_next;
    logic [NW-1:0]   now_fail_reg, now_fail_next;
    logic [NW-1:0]   gnode_reg, gnode_next;
    logic [CW-1:0]   gc_reg, gc_next;
    logic [NW-1:0]   gres_reg, gres_next;
    logic [NW-1:0]   child_reg, child_next;
    logic [15:0]     tacc_reg, tacc_next;
    logic [15:0]     root_acc_reg, root_acc_next;
    logic [TAW-1:0]  clr_reg, clr_next;
    logic            text_mode_reg, text_mode_next;
    logic [1:0]      pend_status_reg, pend_status_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    logic            tt_we;
    logic [TAW-1:0]  tt_waddr, tt_raddr;
    logic [NW-1:0]   tt_wdata, tt_rdata;
    logic            nd_we;
    logic [NW-1:0]   nd_waddr, nd_raddr;
    logic [NDW-1:0]  nd_wdata, nd_rdata;
    logic            q_we;
    logic [NW-1:0]   q_rdata;
    logic [NW-1:0]   nd_fail;
    logic [15:0]     nd_acc;
    logic            sym_ok;
    logic [32:0]     total_sum;

    assign nd_fail   = nd_rdata[NDW-1:16];
    assign nd_acc    = nd_rdata[15:0];
    assign sym_ok    = 32'(item.symbol) < ALPHABET_SIZE;
    assign total_sum = {1'b0, total_reg} + {17'b0, nd_acc};

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    acmpc_ram #(.WIDTH(NW), .DEPTH(TD)) u_trans (
        .clk   (clk),
        .we    (tt_we),
        .waddr (tt_waddr),
        .wdata (tt_wdata),
        .raddr (tt_raddr),
        .rdata (tt_rdata)
    );

    acmpc_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node (
        .clk   (clk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    acmpc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg[NW-1:0]),
        .wdata (child_reg),
        .raddr (head_reg[NW-1:0]),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cursor_reg     <= '0;
            nodes_used_reg <= (NW+1)'(1);
            total_reg      <= '0;
            built_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            nodes_used_reg <= nodes_used_next;
            total_reg      <= total_next;
            built_reg      <= built_next;
            ovf_reg        <= ovf_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg         <= sym_next;
        cidx_reg        <= cidx_next;
        now_reg         <= now_next;
        now_fail_reg    <= now_fail_next;
        gnode_reg       <= gnode_next;
        gc_reg          <= gc_next;
        gres_reg        <= gres_next;
        child_reg       <= child_next;
        tacc_reg        <= tacc_next;
        root_acc_reg    <= root_acc_next;
        text_mode_reg   <= text_mode_next;
        pend_status_reg <= pend_status_next;
        out_reg         <= out_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        sym_next         = sym_reg;
        cursor_next      = cursor_reg;
        nodes_used_next  = nodes_used_reg;
        total_next       = total_reg;
        built_next       = built_reg;
        ovf_next         = ovf_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cidx_next        = cidx_reg;
        now_next         = now_reg;
        now_fail_next    = now_fail_reg;
        gnode_next       = gnode_reg;
        gc_next          = gc_reg;
        gres_next        = gres_reg;
        child_next       = child_reg;
        tacc_next        = tacc_reg;
        root_acc_next    = root_acc_reg;
        clr_next         = clr_reg;
        text_mode_next   = text_mode_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        tt_we            = 1'b0;
        tt_waddr         = tt_addr(cursor_reg, sym_reg);
        tt_wdata         = '0;
        tt_raddr         = '0;
        nd_we            = 1'b0;
        nd_waddr         = cursor_reg;
        nd_wdata         = '0;
        nd_raddr         = '0;
        q_we             = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                tt_we    = 1'b1;
                tt_waddr = clr_reg;
                if (32'(clr_reg) < MAX_NODES)
                begin
                    nd_we    = 1'b1;
                    nd_waddr = NW'(clr_reg);
                end
                clr_next = clr_reg + TAW'(1);
                if (clr_reg == TAW'(TD - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    sym_next         = CW'(item.symbol);
                    pend_status_next = ST_OK;
                    state_next       = S_PUSH;
                    case (item.opcode)
                        OP_BEGIN_PAT:
                        begin
                            if (!built_reg)
                            begin
                                cursor_next = '0;
                                ovf_next    = 1'b0;
                            end
                        end
                        OP_PAT_LETTER:
                        begin
                            if (!built_reg && sym_ok)
                            begin
                                if (ovf_reg)
                                begin
                                    pend_status_next = ST_FULL;
                                end
                                else
                                begin
                                    tt_raddr   = tt_addr(cursor_reg, CW'(item.symbol));
                                    state_next = S_PL_RD;
                                end
                            end
                        end
                        OP_END_PAT:
                        begin
                            if (!built_reg)
                            begin
                                if (ovf_reg)
                                begin
                                    pend_status_next = ST_FULL;
                                    cursor_next      = '0;
                                    ovf_next         = 1'b0;
                                end
                                else
                                begin
                                    nd_raddr   = cursor_reg;
                                    state_next = S_PE_RD;
                                end
                            end
                        end
                        OP_BUILD:
                        begin
                            if (!built_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = S_B_ROOT;
                            end
                        end
                        OP_BEGIN_TEXT:
                        begin
                            total_next  = '0;
                            cursor_next = '0;
                        end
                        OP_TEXT_LETTER:
                        begin
                            if (!built_reg)
                            begin
                                pend_status_next = ST_NO_LINKS;
                            end
                            else if (sym_ok)
                            begin
                                gnode_next     = cursor_reg;
                                gc_next        = CW'(item.symbol);
                                text_mode_next = 1'b1;
                                tt_raddr       = tt_addr(cursor_reg, CW'(item.symbol));
                                state_next     = S_G_TW;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PL_RD:
            begin
                state_next = S_PUSH;
                if (tt_rdata != '0)
                begin
                    cursor_next = tt_rdata;
                end
                else if (32'(nodes_used_reg) < MAX_NODES)
                begin
                    tt_we           = 1'b1;
                    tt_waddr        = tt_addr(cursor_reg, sym_reg);
                    tt_wdata        = NW'(nodes_used_reg);
                    cursor_next     = NW'(nodes_used_reg);
                    nodes_used_next = nodes_used_reg + (NW+1)'(1);
                end
                else
                begin
                    ovf_next         = 1'b1;
                    pend_status_next = ST_FULL;
                end
            end
            S_PE_RD:
            begin
                nd_we       = 1'b1;
                nd_waddr    = cursor_reg;
                nd_wdata    = {nd_fail, sat16(nd_acc, 16'd1)};
                cursor_next = '0;
                state_next  = S_PUSH;
            end
            S_B_ROOT:
            begin
                nd_raddr   = '0;
                state_next = S_B_ROOTW;
            end
            S_B_ROOTW:
            begin
                root_acc_next = nd_acc;
                cidx_next     = '0;
                state_next    = S_B_R0;
            end
            S_B_R0:
            begin
                if (cidx_reg == CW'(ALPHABET_SIZE))
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    tt_raddr   = tt_addr('0, cidx_reg);
                    state_next = S_B_R0W;
                end
            end
            S_B_R0W:
            begin
                if (tt_rdata == '0)
                begin
                    cidx_next  = cidx_reg + CW'(1);
                    state_next = S_B_R0;
                end
                else
                begin
                    child_next = tt_rdata;
                    nd_raddr   = tt_rdata;
                    state_next = S_B_R0A;
                end
            end
            S_B_R0A:
            begin
                nd_we      = 1'b1;
                nd_waddr   = child_reg;
                nd_wdata   = {NW'(0), sat16(nd_acc, root_acc_reg)};
                q_we       = 1'b1;
                tail_next  = tail_reg + (NW+1)'(1);
                cidx_next  = cidx_reg + CW'(1);
                state_next = S_B_R0;
            end
            S_B_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                    state_next = S_PUSH;
                end
                else
                begin
                    head_next  = head_reg + (NW+1)'(1);
                    state_next = S_B_POPW;
                end
            end
            S_B_POPW:
            begin
                now_next   = q_rdata;
                nd_raddr   = q_rdata;
                state_next = S_B_NF;
            end
            S_B_NF:
            begin
                now_fail_next = nd_fail;
                cidx_next     = '0;
                state_next    = S_B_CH;
            end
            S_B_CH:
            begin
                if (cidx_reg == CW'(ALPHABET_SIZE))
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    tt_raddr   = tt_addr(now_reg, cidx_reg);
                    state_next = S_B_CHW;
                end
            end
            S_B_CHW:
            begin
                if (tt_rdata == '0)
                begin
                    cidx_next  = cidx_reg + CW'(1);
                    state_next = S_B_CH;
                end
                else
                begin
                    child_next     = tt_rdata;
                    gnode_next     = now_fail_reg;
                    gc_next        = cidx_reg;
                    text_mode_next = 1'b0;
                    tt_raddr       = tt_addr(now_fail_reg, cidx_reg);
                    state_next     = S_G_TW;
                end
            end
            // failure walk shared by build and text
            S_G_TW:
            begin
                if (tt_rdata != '0 || gnode_reg == '0)
                begin
                    gres_next  = tt_rdata;
                    nd_raddr   = tt_rdata;
                    state_next = text_mode_reg ? S_T_AW : S_B_TACC;
                end
                else
                begin
                    nd_raddr   = gnode_reg;
                    state_next = S_G_FW;
                end
            end
            S_G_FW:
            begin
                gnode_next = nd_fail;
                tt_raddr   = tt_addr(nd_fail, gc_reg);
                state_next = S_G_TW;
            end
            S_B_TACC:
            begin
                tacc_next  = nd_acc;
                nd_raddr   = child_reg;
                state_next = S_B_WR;
            end
            S_B_WR:
            begin
                nd_we      = 1'b1;
                nd_waddr   = child_reg;
                nd_wdata   = {gres_reg, sat16(nd_acc, tacc_reg)};
                q_we       = 1'b1;
                tail_next  = tail_reg + (NW+1)'(1);
                cidx_next  = cidx_reg + CW'(1);
                state_next = S_B_CH;
            end
            S_T_AW:
            begin
                cursor_next = gres_reg;
                total_next  = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
                state_next  = S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.match_total = total_reg;
                    out_next.status      = pend_status_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_built_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        built_reg |=> built_reg)
        else $error("links built flag dropped");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nodes_used_reg != '0) && (32'(nodes_used_reg) <= MAX_NODES))
        else $error("node count out of range");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (32'(nodes_used_reg) == MAX_NODES))
        else $error("overflow flagged with free nodes");

endmodule
